[hw/rtl/rect_ovl_pkg.sv]
`timescale 1ns / 1ps

package rect_ovl_pkg;

   localparam int COORD_BITS       = 16;
   localparam int WORD_W           = 2 * COORD_BITS;
   localparam int AXIS_W           = COORD_BITS + 1;
   localparam int PROD_W           = COORD_BITS + AXIS_W;
   localparam int DOT_W            = PROD_W + 1;
   localparam int NUM_CORNERS      = 8;
   localparam int CORNERS_PER_RECT = 4;
   localparam int NUM_AXES         = 4;

   localparam int A_TL = 0;
   localparam int A_TR = 1;
   localparam int A_BL = 2;
   localparam int A_BR = 3;
   localparam int B_TL = 4;
   localparam int B_TR = 5;
   localparam int B_BL = 6;
   localparam int B_BR = 7;

   typedef logic [WORD_W-1:0] word_type;

   typedef struct packed {
      logic signed [COORD_BITS-1:0] x;
      logic signed [COORD_BITS-1:0] y;
   } point_type;

   typedef struct packed {
      logic signed [AXIS_W-1:0] x;
      logic signed [AXIS_W-1:0] y;
   } axis_type;

   typedef logic signed [DOT_W-1:0] dot_type;

endpackage

[hw/rtl/oriented_rect_overlap_test.sv]
`timescale 1ns / 1ps
// Throughput: one word per cycle while rsp_stall is low; the input, projection
// and result registers each advance whenever the stage after them is empty or
// being emptied, and an accepted word passes them in turn to rsp_valid.
// Reset is synchronous and active high; it clears all valid flags, so no
// result is presented and req_stall is low after reset.
module oriented_rect_overlap_test (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  rect_ovl_pkg::word_type  req_rect_a_top_left,
   input  rect_ovl_pkg::word_type  req_rect_a_top_right,
   input  rect_ovl_pkg::word_type  req_rect_a_bottom_left,
   input  rect_ovl_pkg::word_type  req_rect_a_bottom_right,
   input  rect_ovl_pkg::word_type  req_rect_b_top_left,
   input  rect_ovl_pkg::word_type  req_rect_b_top_right,
   input  rect_ovl_pkg::word_type  req_rect_b_bottom_left,
   input  rect_ovl_pkg::word_type  req_rect_b_bottom_right,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic                    rsp_overlap
);
   import rect_ovl_pkg::*;

   logic      s0_valid_ff;
   logic      s0_valid_in;
   point_type s0_corner_ff [NUM_CORNERS];
   point_type s0_corner_in [NUM_CORNERS];
   logic      s1_valid_ff;
   logic      s1_valid_in;
   dot_type   s1_dot_ff [NUM_AXES][NUM_CORNERS];
   dot_type   s1_dot_in [NUM_AXES][NUM_CORNERS];
   logic      rsp_valid_ff;
   logic      rsp_valid_in;
   logic      rsp_overlap_ff;
   logic      rsp_overlap_in;

   point_type req_corner [NUM_CORNERS];
   dot_type   proj_dot [NUM_AXES][NUM_CORNERS];
   logic      sep_overlap;
   logic      out_free;
   logic      s1_free;
   logic      s0_free;

   rect_ovl_proj u_proj (
      .corner_i (s0_corner_ff),
      .dot_o    (proj_dot)
   );

   rect_ovl_sep u_sep (
      .dot_i     (s1_dot_ff),
      .overlap_o (sep_overlap)
   );

   always_comb begin
      req_corner[A_TL] = point_type'(req_rect_a_top_left);
      req_corner[A_TR] = point_type'(req_rect_a_top_right);
      req_corner[A_BL] = point_type'(req_rect_a_bottom_left);
      req_corner[A_BR] = point_type'(req_rect_a_bottom_right);
      req_corner[B_TL] = point_type'(req_rect_b_top_left);
      req_corner[B_TR] = point_type'(req_rect_b_top_right);
      req_corner[B_BL] = point_type'(req_rect_b_bottom_left);
      req_corner[B_BR] = point_type'(req_rect_b_bottom_right);

      out_free = !rsp_valid_ff || !rsp_stall;
      s1_free  = !s1_valid_ff || out_free;
      s0_free  = !s0_valid_ff || s1_free;

      s0_valid_in    = s0_free ? req_valid : s0_valid_ff;
      s1_valid_in    = s1_free ? s0_valid_ff : s1_valid_ff;
      rsp_valid_in   = out_free ? s1_valid_ff : rsp_valid_ff;
      s0_corner_in   = s0_corner_ff;
      if (s0_free && req_valid) begin
         s0_corner_in = req_corner;
      end
      s1_dot_in      = s1_dot_ff;
      if (s1_free && s0_valid_ff) begin
         s1_dot_in = proj_dot;
      end
      rsp_overlap_in = (out_free && s1_valid_ff) ? sep_overlap : rsp_overlap_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff  <= 1'b0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s0_valid_ff  <= s0_valid_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s0_corner_ff   <= s0_corner_in;
      s1_dot_ff      <= s1_dot_in;
      rsp_overlap_ff <= rsp_overlap_in;
   end

   assign req_stall   = !s0_free;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_overlap = rsp_overlap_ff;

endmodule

[hw/rtl/rect_ovl_proj.sv]
`timescale 1ns / 1ps

module rect_ovl_proj (
   input  rect_ovl_pkg::point_type corner_i [rect_ovl_pkg::NUM_CORNERS],
   output rect_ovl_pkg::dot_type   dot_o    [rect_ovl_pkg::NUM_AXES][rect_ovl_pkg::NUM_CORNERS]
);
   import rect_ovl_pkg::*;

   axis_type axis [NUM_AXES];

   function automatic axis_type diff_fn(input point_type p, input point_type q);
      axis_type r;
      r.x = AXIS_W'($signed(p.x)) - AXIS_W'($signed(q.x));
      r.y = AXIS_W'($signed(p.y)) - AXIS_W'($signed(q.y));
      return r;
   endfunction

   function automatic dot_type dot_fn(input point_type p, input axis_type a);
      logic signed [PROD_W-1:0] px;
      logic signed [PROD_W-1:0] py;
      px = PROD_W'($signed(p.x)) * PROD_W'($signed(a.x));
      py = PROD_W'($signed(p.y)) * PROD_W'($signed(a.y));
      return DOT_W'(px) + DOT_W'(py);
   endfunction

   always_comb begin
      axis[0] = diff_fn(corner_i[A_TR], corner_i[A_TL]);
      axis[1] = diff_fn(corner_i[A_TR], corner_i[A_BR]);
      axis[2] = diff_fn(corner_i[B_TL], corner_i[B_BL]);
      axis[3] = diff_fn(corner_i[B_TL], corner_i[B_TR]);
      for (int k = 0; k < NUM_AXES; k++) begin
         for (int c = 0; c < NUM_CORNERS; c++) begin
            dot_o[k][c] = dot_fn(corner_i[c], axis[k]);
         end
      end
   end

endmodule

[hw/rtl/rect_ovl_sep.sv]
`timescale 1ns / 1ps

module rect_ovl_sep (
   input  rect_ovl_pkg::dot_type dot_i [rect_ovl_pkg::NUM_AXES][rect_ovl_pkg::NUM_CORNERS],
   output logic                  overlap_o
);
   import rect_ovl_pkg::*;

   dot_type                a_lo [NUM_AXES];
   dot_type                a_hi [NUM_AXES];
   dot_type                b_lo [NUM_AXES];
   dot_type                b_hi [NUM_AXES];
   logic [NUM_AXES-1:0]    separate;

   always_comb begin
      for (int k = 0; k < NUM_AXES; k++) begin
         a_lo[k] = dot_i[k][0];
         a_hi[k] = dot_i[k][0];
         b_lo[k] = dot_i[k][CORNERS_PER_RECT];
         b_hi[k] = dot_i[k][CORNERS_PER_RECT];
         for (int c = 1; c < CORNERS_PER_RECT; c++) begin
            if (dot_i[k][c] < a_lo[k]) begin
               a_lo[k] = dot_i[k][c];
            end
            if (dot_i[k][c] > a_hi[k]) begin
               a_hi[k] = dot_i[k][c];
            end
            if (dot_i[k][CORNERS_PER_RECT + c] < b_lo[k]) begin
               b_lo[k] = dot_i[k][CORNERS_PER_RECT + c];
            end
            if (dot_i[k][CORNERS_PER_RECT + c] > b_hi[k]) begin
               b_hi[k] = dot_i[k][CORNERS_PER_RECT + c];
            end
         end
         separate[k] = (a_hi[k] < b_lo[k]) || (b_hi[k] < a_lo[k]);
      end
      overlap_o = ~|separate;
   end

endmodule

[hw/rtl/rect_ovl_checker.sv]
`timescale 1ns / 1ps

module rect_ovl_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_stall,
   input logic rsp_valid,
   input logic rsp_stall,
   input logic rsp_overlap
);

   // A stalled result word holds until it is taken.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_overlap))
      else $error("result word changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // The input side only backs up when the result side is full and stalled.
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("input stalled without output backpressure");

   // With a free output, an accepted word reaches rsp_valid.
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) ##1 !rsp_stall ##1 !rsp_stall |=> rsp_valid)
      else $error("accepted word did not reach the output");

endmodule

bind oriented_rect_overlap_test rect_ovl_checker u_checker (.*);
